>>> sv/positional_linked_list_engine_core_macros.svh
// Assertion macros for the linked list engine core.
`ifndef POSITIONAL_LINKED_LIST_ENGINE_CORE_MACROS_SVH
`define POSITIONAL_LINKED_LIST_ENGINE_CORE_MACROS_SVH
// Implication checked every clock, masked during reset.
`define PLL_ASSERT_IMP(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// Next-cycle implication, masked during reset.
`define PLL_ASSERT_NXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

>>> sv/pll_pkg.sv
// Shared types and constants for the linked list engine.
package pll_pkg;
   localparam int Capacity = 256;
   localparam int ValueWidth = 32;
   localparam int SlotWidth = $clog2(Capacity);
   localparam int CountWidth = $clog2(Capacity + 1);

   localparam logic [2:0] OP_ADD_FRONT = 3'd0;
   localparam logic [2:0] OP_ADD_END = 3'd1;
   localparam logic [2:0] OP_REM_FRONT = 3'd2;
   localparam logic [2:0] OP_REM_END = 3'd3;
   localparam logic [2:0] OP_INSERT = 3'd4;
   localparam logic [2:0] OP_REM_AT = 3'd5;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_IGNORED = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   // Datapath commands issued by the controller.
   localparam logic [3:0] CMD_NONE = 4'd0;
   localparam logic [3:0] CMD_LATCH = 4'd1;  // capture request word
   localparam logic [3:0] CMD_WALK_START = 4'd2;  // cursor = head, read link
   localparam logic [3:0] CMD_WALK_STEP = 4'd3;  // cursor = link read data
   localparam logic [3:0] CMD_ADD_FRONT = 4'd4;
   localparam logic [3:0] CMD_ADD_END = 4'd5;
   localparam logic [3:0] CMD_REM_FRONT = 4'd6;
   localparam logic [3:0] CMD_REM_END = 4'd7;  // cursor is predecessor
   localparam logic [3:0] CMD_INS_MID = 4'd8;  // cursor is position node
   localparam logic [3:0] CMD_REM_MID_A = 4'd9;  // cursor is predecessor
   localparam logic [3:0] CMD_REM_MID_B = 4'd10; // victim link read back
   localparam logic [3:0] CMD_REPORT_RD = 4'd11; // latch result status (head and tail values are read every cycle)
   localparam logic [3:0] CMD_FREE_RD = 4'd12; // read link of free head

   typedef struct packed {
      logic [3:0] cmd;
      logic [1:0] status;
   } ctl_type;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] pos;
      logic [CountWidth-1:0] count;
      logic have_slot;
      logic from_free;
   } sts_type;
endpackage

>>> sv/positional_linked_list_engine_core.sv
// Each word is latched on the accept edge; positional words and end removes follow links
// one per cycle through the link read port, at most 254 links per word.
// Throughput: one word at a time; busy is high through the strobe cycle.
// Reset (synchronous, active high) empties the list; the pool needs no clearing pass.
// The receiver cannot stall: each result word is shown for exactly one cycle.
module positional_linked_list_engine_core (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input logic [2:0] req_operation,
   input logic signed [31:0] req_value,
   input logic [7:0] req_position,
   output logic rsp_valid,
   output logic [1:0] rsp_status,
   output logic signed [31:0] rsp_first_value,
   output logic signed [31:0] rsp_last_value,
   output logic [8:0] rsp_element_count,
   output logic rsp_is_empty
);
   import pll_pkg::*;
`include "positional_linked_list_engine_core_macros.svh"

   ctl_type ctl;
   sts_type sts;

   pll_controller u_ctl (
      .clock, .reset, .start, .busy, .rsp_valid, .ctl, .sts
   );

   pll_datapath u_dp (
      .clock, .reset, .req_operation, .req_value, .req_position, .ctl, .sts,
      .rsp_status, .rsp_first_value, .rsp_last_value, .rsp_element_count,
      .rsp_is_empty
   );

   `PLL_ASSERT_IMP(a_empty_count, clock, reset, 1'b1, rsp_is_empty == (rsp_element_count == 9'd0), "empty flag disagrees with count")
   `PLL_ASSERT_NXT(a_strobe_one, clock, reset, rsp_valid, !rsp_valid, "result strobe longer than one cycle")
   `PLL_ASSERT_IMP(a_cap, clock, reset, 1'b1, rsp_element_count <= 9'(Capacity), "count above capacity")
endmodule

>>> sv/pll_datapath.sv
// Datapath: node pool memories, list pointers, cursor and result registers.
module pll_datapath (
   input logic clock,
   input logic reset,
   input logic [2:0] req_operation,
   input logic signed [31:0] req_value,
   input logic [7:0] req_position,
   input pll_pkg::ctl_type ctl,
   output pll_pkg::sts_type sts,
   output logic [1:0] rsp_status,
   output logic signed [31:0] rsp_first_value,
   output logic signed [31:0] rsp_last_value,
   output logic [8:0] rsp_element_count,
   output logic rsp_is_empty
);
   import pll_pkg::*;

   logic [ValueWidth-1:0] val_mem [Capacity];
   logic [SlotWidth-1:0] link_mem [Capacity];

   logic [2:0] op_ff;
   logic [7:0] pos_ff;
   logic [ValueWidth-1:0] val_ff;
   logic [SlotWidth-1:0] head_ff, tail_ff, free_head_ff, cursor_ff, victim_ff;
   logic [CountWidth-1:0] count_ff, free_count_ff, fresh_ff;
   logic [SlotWidth-1:0] link_rd_ff;
   logic [ValueWidth-1:0] hval_ff, tval_ff;
   logic [1:0] status_ff;

   // free-list successor kept across the insert walk
   logic free_rd_ff;
   logic [SlotWidth-1:0] free_next_ff;

   // deferred second link write for insert middle and remove middle
   logic wr2_we_ff;
   logic [SlotWidth-1:0] wr2_wa_ff, wr2_wd_ff;

   // link write port and read address
   logic link_we;
   logic [SlotWidth-1:0] link_wa, link_wd, link_ra;
   logic val_we;
   logic [SlotWidth-1:0] val_wa, new_slot, free_next;
   logic from_free;

   assign from_free = (free_count_ff != '0);
   assign new_slot = from_free ? free_head_ff : fresh_ff[SlotWidth-1:0];
   // adds run right after the prefetch; insert walks first, so use the saved copy
   assign free_next = (ctl.cmd == CMD_INS_MID) ? free_next_ff : link_rd_ff;

   assign sts.op = op_ff;
   assign sts.pos = pos_ff;
   assign sts.count = count_ff;
   assign sts.have_slot = from_free || (fresh_ff < CountWidth'(Capacity));
   assign sts.from_free = from_free;

   // memory port control
   always_comb begin
      link_we = 1'b0;
      link_wa = new_slot;
      link_wd = '0;
      link_ra = cursor_ff;
      val_we = 1'b0;
      val_wa = new_slot;
      case (ctl.cmd)
         CMD_FREE_RD: link_ra = free_head_ff;
         CMD_WALK_START: link_ra = head_ff;
         CMD_WALK_STEP: link_ra = link_rd_ff;
         CMD_ADD_FRONT: begin
            link_we = 1'b1; link_wd = head_ff; val_we = 1'b1;
         end
         CMD_ADD_END: begin
            val_we = 1'b1;
            if (count_ff == '0) begin
               link_we = 1'b1; link_wd = '0;
            end else begin
               // new node's link stays unwritten until it gets a successor
               link_we = 1'b1; link_wa = tail_ff; link_wd = new_slot;
            end
         end
         CMD_REM_FRONT: begin
            link_we = 1'b1; link_wa = head_ff; link_wd = free_head_ff;
         end
         CMD_REM_END: begin
            link_we = 1'b1; link_wa = tail_ff; link_wd = free_head_ff;
         end
         CMD_INS_MID: begin
            link_we = 1'b1; link_wa = new_slot; link_wd = link_rd_ff; val_we = 1'b1;
         end
         CMD_REM_MID_A: link_ra = link_rd_ff;
         CMD_REM_MID_B: begin
            link_we = 1'b1; link_wa = cursor_ff; link_wd = link_rd_ff;
         end
         default: ;
      endcase
   end

   // pool memories, one link write per cycle
   always_ff @(posedge clock) begin
      if (wr2_we_ff) link_mem[wr2_wa_ff] <= wr2_wd_ff;
      else if (link_we) link_mem[link_wa] <= link_wd;
      if (val_we) val_mem[val_wa] <= val_ff;
      link_rd_ff <= link_mem[link_ra];
      hval_ff <= val_mem[head_ff];
      tval_ff <= val_mem[tail_ff];
   end

   // second link write lands in the pad cycle that follows
   always_ff @(posedge clock) begin
      if (reset) begin
         free_rd_ff <= 1'b0;
         wr2_we_ff <= 1'b0;
      end else begin
         free_rd_ff <= (ctl.cmd == CMD_FREE_RD);
         wr2_we_ff <= (ctl.cmd == CMD_INS_MID) || (ctl.cmd == CMD_REM_MID_B);
      end
   end

   always_ff @(posedge clock) begin
      if (free_rd_ff) free_next_ff <= link_rd_ff;
      case (ctl.cmd)
         CMD_INS_MID: begin
            wr2_wa_ff <= cursor_ff; wr2_wd_ff <= new_slot;
         end
         CMD_REM_MID_B: begin
            wr2_wa_ff <= victim_ff; wr2_wd_ff <= free_head_ff;
         end
         default: ;
      endcase
   end

   // request capture and list pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0; tail_ff <= '0; count_ff <= '0;
         free_head_ff <= '0; free_count_ff <= '0; fresh_ff <= '0;
         status_ff <= ST_DONE;
      end else begin
         case (ctl.cmd)
            CMD_LATCH: begin
               op_ff <= req_operation; pos_ff <= req_position;
               val_ff <= req_value[ValueWidth-1:0];
            end
            CMD_WALK_START: cursor_ff <= head_ff;
            CMD_WALK_STEP: cursor_ff <= link_rd_ff;
            CMD_ADD_FRONT, CMD_ADD_END, CMD_INS_MID: begin
               if (from_free) begin
                  free_head_ff <= free_next;
                  free_count_ff <= free_count_ff - 1'b1;
               end else begin
                  fresh_ff <= fresh_ff + 1'b1;
               end
               count_ff <= count_ff + 1'b1;
               if (ctl.cmd == CMD_ADD_FRONT) begin
                  head_ff <= new_slot;
                  if (count_ff == '0) tail_ff <= new_slot;
               end else if (ctl.cmd == CMD_ADD_END) begin
                  tail_ff <= new_slot;
                  if (count_ff == '0) head_ff <= new_slot;
               end
            end
            CMD_REM_FRONT: begin
               free_head_ff <= head_ff;
               free_count_ff <= free_count_ff + 1'b1;
               count_ff <= count_ff - 1'b1;
               if (count_ff == CountWidth'(1)) begin
                  head_ff <= '0; tail_ff <= '0;
               end else begin
                  head_ff <= link_rd_ff;
               end
            end
            CMD_REM_END: begin
               free_head_ff <= tail_ff;
               free_count_ff <= free_count_ff + 1'b1;
               count_ff <= count_ff - 1'b1;
               tail_ff <= cursor_ff;
            end
            CMD_REM_MID_A: victim_ff <= link_rd_ff;
            CMD_REM_MID_B: begin
               free_head_ff <= victim_ff;
               free_count_ff <= free_count_ff + 1'b1;
               count_ff <= count_ff - 1'b1;
            end
            default: ;
         endcase
         if (ctl.cmd == CMD_REPORT_RD) status_ff <= ctl.status;
      end
   end

   // result word, sign-extended values
   logic empty;
   assign empty = (count_ff == '0);
   assign rsp_status = status_ff;
   assign rsp_first_value = empty ? 32'sd0 : 32'(signed'(hval_ff));
   assign rsp_last_value = empty ? 32'sd0 : 32'(signed'(tval_ff));
   assign rsp_element_count = 9'(count_ff);
   assign rsp_is_empty = empty;
endmodule

>>> sv/pll_controller.sv
// Controller: sequences each operation word through datapath commands.
module pll_controller (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   output logic rsp_valid,
   output pll_pkg::ctl_type ctl,
   input pll_pkg::sts_type sts
);
   import pll_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_FREE = 4'd2;
   localparam logic [3:0] S_ADD = 4'd3;
   localparam logic [3:0] S_WALK = 4'd4;
   localparam logic [3:0] S_WAIT = 4'd5;
   localparam logic [3:0] S_FINISH = 4'd6;
   localparam logic [3:0] S_REPORT = 4'd7;
   localparam logic [3:0] S_OUT = 4'd8;
   localparam logic [3:0] S_RDHEAD = 4'd9;
   localparam logic [3:0] S_MIDB = 4'd10;
   localparam logic [3:0] S_PAD = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [3:0] act_ff, act_in;     // list command of this operation, issued after any walk
   logic [7:0] steps_ff, steps_in; // walk steps remaining
   logic [1:0] status_ff, status_in;

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff; act_in = act_ff; steps_in = steps_ff; status_in = status_ff;
      ctl.cmd = CMD_NONE; ctl.status = status_ff;
      case (state_ff)
         S_IDLE: if (start) begin
            ctl.cmd = CMD_LATCH; state_in = S_DECODE;
         end
         S_DECODE: begin
            status_in = ST_DONE; state_in = S_REPORT;
            case (sts.op)
               OP_ADD_FRONT, OP_ADD_END: begin
                  act_in = (sts.op == OP_ADD_FRONT) ? CMD_ADD_FRONT : CMD_ADD_END;
                  state_in = S_FREE;
               end
               OP_REM_FRONT: if (sts.count == '0) status_in = ST_IGNORED;
                  else begin act_in = CMD_REM_FRONT; state_in = S_RDHEAD; end
               OP_REM_END: if (sts.count == '0) status_in = ST_IGNORED;
                  else if (sts.count == 9'd1) begin
                     act_in = CMD_REM_FRONT; state_in = S_RDHEAD;
                  end else begin
                     act_in = CMD_REM_END; steps_in = 8'(sts.count - 9'd2);
                     state_in = S_WALK;
                  end
               OP_INSERT: if (sts.count == '0) begin
                     act_in = CMD_ADD_FRONT; state_in = S_FREE;
                  end else if (9'(sts.pos) >= sts.count) status_in = ST_IGNORED;
                  else if (9'(sts.pos) == sts.count - 9'd1) begin
                     act_in = CMD_ADD_END; state_in = S_FREE;
                  end else begin
                     act_in = CMD_INS_MID; state_in = S_FREE;
                  end
               OP_REM_AT: if (9'(sts.pos) >= sts.count) status_in = ST_IGNORED;
                  else if (sts.pos == 8'd0) begin
                     act_in = CMD_REM_FRONT; state_in = S_RDHEAD;
                  end else if (9'(sts.pos) == sts.count - 9'd1) begin
                     act_in = CMD_REM_END; steps_in = 8'(sts.count - 9'd2);
                     state_in = S_WALK;
                  end else begin
                     act_in = CMD_REM_MID_A; steps_in = sts.pos - 8'd1;
                     state_in = S_WALK;
                  end
               default: status_in = ST_IGNORED;
            endcase
         end
         // adds: check for a slot, prefetch free-list successor, walk first for a middle insert
         S_FREE: if (!sts.have_slot) begin
               status_in = ST_FULL; state_in = S_REPORT;
            end else begin
               ctl.cmd = CMD_FREE_RD;
               if (act_ff == CMD_INS_MID) begin
                  steps_in = sts.pos; state_in = S_WALK;
               end else state_in = S_ADD;
            end
         S_ADD: begin ctl.cmd = act_ff; state_in = S_PAD; end
         S_RDHEAD: begin ctl.cmd = CMD_WALK_START; steps_in = 8'd0; state_in = S_WAIT; end
         S_WALK: begin
            // walk restarts at the head; for an insert the datapath saves the free successor
            ctl.cmd = CMD_WALK_START; state_in = S_WAIT;
         end
         S_WAIT: if (steps_ff == 8'd0) state_in = S_FINISH;
            else begin
               ctl.cmd = CMD_WALK_STEP; steps_in = steps_ff - 8'd1;
            end
         S_FINISH: begin
            ctl.cmd = act_ff;
            state_in = (act_ff == CMD_REM_MID_A) ? S_MIDB : S_PAD;
         end
         S_MIDB: begin ctl.cmd = CMD_REM_MID_B; state_in = S_PAD; end
         S_PAD: state_in = S_REPORT;
         S_REPORT: begin ctl.cmd = CMD_REPORT_RD; state_in = S_OUT; end
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; act_ff <= CMD_NONE; steps_ff <= '0; status_ff <= ST_DONE;
      end else begin
         state_ff <= state_in; act_ff <= act_in; steps_ff <= steps_in;
         status_ff <= status_in;
      end
   end
endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the linked list engine core: directed table, pool fill, then random words.
`timescale 1ns / 100ps

module tb_top;
   import pll_pkg::*;

   // operation codes with no defined action
   localparam logic [2:0] OP_BAD_LOW = 3'd6;
   localparam logic [2:0] OP_BAD_HIGH = 3'd7;

   typedef struct {
      logic [1:0] status;
      logic signed [31:0] first_value;
      logic signed [31:0] last_value;
      logic [8:0] element_count;
      logic is_empty;
   } list_report_type;

   typedef struct {
      logic [2:0] op;
      logic signed [31:0] value;
      logic [7:0] pos;
      bit typed;
      list_report_type report;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [2:0] req_operation = OP_ADD_FRONT;
   logic signed [31:0] req_value = '0;
   logic [7:0] req_position = '0;
   logic rsp_valid;
   logic [1:0] rsp_status;
   logic signed [31:0] rsp_first_value;
   logic signed [31:0] rsp_last_value;
   logic [8:0] rsp_element_count;
   logic rsp_is_empty;

   // Shadow copy of the list state
   logic [31:0] pool_value [Capacity];
   logic [7:0] pool_link [Capacity];
   logic [7:0] head_q, tail_q, free_head_q;
   int unsigned list_len, free_len, fresh_used;

   list_report_type pending_reports[$];
   int unsigned mismatch_count = 0;
   int unsigned sender_idle_pct = 0;

   positional_linked_list_engine_core DUT (.*);

   always #5 clock = ~clock;

   initial begin
      #100ms;
      $display("Mismatches found");
      $finish;
   end

   // Slot allocation: recycled slots first, then fresh ones in order
   function automatic bit grab_slot(output logic [7:0] s);
      if (free_len > 0) begin
         s = free_head_q;
         free_head_q = pool_link[s];
         free_len--;
         return 1'b1;
      end
      if (fresh_used < Capacity) begin
         s = fresh_used[7:0];
         fresh_used++;
         return 1'b1;
      end
      s = '0;
      return 1'b0;
   endfunction

   function automatic void release_slot(logic [7:0] s);
      pool_link[s] = free_head_q;
      free_head_q = s;
      free_len++;
   endfunction

   function automatic logic [7:0] follow(int unsigned steps);
      logic [7:0] s;
      s = head_q;
      for (int unsigned i = 0; i < steps; i++) s = pool_link[s];
      return s;
   endfunction

   function automatic logic [1:0] push_front(logic [31:0] v);
      logic [7:0] s;
      if (!grab_slot(s)) return ST_FULL;
      pool_value[s] = v;
      pool_link[s] = head_q;
      if (list_len == 0) tail_q = s;
      head_q = s;
      list_len++;
      return ST_DONE;
   endfunction

   function automatic logic [1:0] push_back(logic [31:0] v);
      logic [7:0] s;
      if (!grab_slot(s)) return ST_FULL;
      pool_value[s] = v;
      pool_link[s] = '0;
      if (list_len == 0) head_q = s;
      else pool_link[tail_q] = s;
      tail_q = s;
      list_len++;
      return ST_DONE;
   endfunction

   function automatic logic [1:0] pop_front();
      logic [7:0] old;
      if (list_len == 0) return ST_IGNORED;
      old = head_q;
      head_q = pool_link[old];
      release_slot(old);
      list_len--;
      if (list_len == 0) begin
         head_q = '0;
         tail_q = '0;
      end
      return ST_DONE;
   endfunction

   function automatic logic [1:0] pop_back();
      logic [7:0] pred;
      if (list_len == 0) return ST_IGNORED;
      if (list_len == 1) return pop_front();
      pred = follow(list_len - 2);
      release_slot(tail_q);
      tail_q = pred;
      pool_link[pred] = '0;
      list_len--;
      return ST_DONE;
   endfunction

   // Applies one word to the shadow list and returns the report it should produce
   function automatic list_report_type apply_word(logic [2:0] op, logic [31:0] v,
                                                  logic [7:0] pos);
      list_report_type r;
      logic [7:0] s, at, pred, victim;
      logic [1:0] st;
      case (op)
         OP_ADD_FRONT: st = push_front(v);
         OP_ADD_END: st = push_back(v);
         OP_REM_FRONT: st = pop_front();
         OP_REM_END: st = pop_back();
         OP_INSERT: begin
            if (list_len == 0) st = push_front(v);
            else if (pos >= list_len) st = ST_IGNORED;
            else if (pos == list_len - 1) st = push_back(v);
            else if (!grab_slot(s)) st = ST_FULL;
            else begin
               at = follow(pos);
               pool_value[s] = v;
               pool_link[s] = pool_link[at];
               pool_link[at] = s;
               list_len++;
               st = ST_DONE;
            end
         end
         OP_REM_AT: begin
            if (list_len == 0 || pos >= list_len) st = ST_IGNORED;
            else if (pos == 0) st = pop_front();
            else if (pos == list_len - 1) st = pop_back();
            else begin
               pred = follow(pos - 1);
               victim = pool_link[pred];
               pool_link[pred] = pool_link[victim];
               release_slot(victim);
               list_len--;
               st = ST_DONE;
            end
         end
         default: st = ST_IGNORED;
      endcase
      r.status = st;
      r.first_value = list_len != 0 ? pool_value[head_q] : '0;
      r.last_value = list_len != 0 ? pool_value[tail_q] : '0;
      r.element_count = list_len[8:0];
      r.is_empty = list_len == 0;
      return r;
   endfunction

   // Issue one word once the engine is free; sender gaps fall before it
   task automatic issue_word(logic [2:0] op, logic signed [31:0] v, logic [7:0] pos,
                             bit typed = 0,
                             list_report_type typed_report = '{default: '0});
      list_report_type r;
      while ($urandom_range(99) < sender_idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      while (busy) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_operation = op;
      req_value = v;
      req_position = pos;
      r = apply_word(op, v, pos);
      if (typed) pending_reports.push_back(typed_report);
      else pending_reports.push_back(r);
      @(negedge clock);
   endtask

   // Result checker
   always @(posedge clock) begin
      list_report_type e;
      if (!reset && rsp_valid) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected result word status %0d count %0d", $time,
                     rsp_status, rsp_element_count);
            mismatch_count++;
         end else begin
            e = pending_reports.pop_front();
            if (rsp_status !== e.status) begin
               $display("%0t: status exp %0d got %0d", $time, e.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_first_value !== e.first_value) begin
               $display("%0t: first_value exp %0d got %0d", $time, e.first_value,
                        rsp_first_value);
               mismatch_count++;
            end
            if (rsp_last_value !== e.last_value) begin
               $display("%0t: last_value exp %0d got %0d", $time, e.last_value,
                        rsp_last_value);
               mismatch_count++;
            end
            if (rsp_element_count !== e.element_count) begin
               $display("%0t: element_count exp %0d got %0d", $time, e.element_count,
                        rsp_element_count);
               mismatch_count++;
            end
            if (rsp_is_empty !== e.is_empty) begin
               $display("%0t: is_empty exp %0b got %0b", $time, e.is_empty, rsp_is_empty);
               mismatch_count++;
            end
         end
      end
   end

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(9))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return -32'sd1;
         3: return '0;
         default: return $urandom;
      endcase
   endfunction

   // Random word; add_pct biases the list toward filling or draining
   task automatic random_word(int unsigned add_pct);
      logic [2:0] op;
      logic [7:0] pos;
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 3) op = $urandom_range(1) ? OP_BAD_HIGH : OP_BAD_LOW;
      else if (roll < add_pct) op = $urandom_range(2) == 0 ? OP_ADD_FRONT :
                                    ($urandom_range(1) ? OP_ADD_END : OP_INSERT);
      else begin
         case ($urandom_range(2))
            0: op = OP_REM_FRONT;
            1: op = OP_REM_END;
            default: op = OP_REM_AT;
         endcase
      end
      if ($urandom_range(7) == 0 || list_len == 0) pos = 8'($urandom_range(255));
      else pos = 8'($urandom_range(list_len - 1 + ($urandom_range(5) == 0)));
      issue_word(op, pick_value(), pos);
   endtask

   table_row_type stim_table [] = '{
      '{OP_REM_FRONT, 0, 0, 1, '{ST_IGNORED, 0, 0, 0, 1}},
      '{OP_REM_END, 0, 0, 1, '{ST_IGNORED, 0, 0, 0, 1}},
      '{OP_REM_AT, 0, 0, 1, '{ST_IGNORED, 0, 0, 0, 1}},
      '{OP_INSERT, 32'sh7FFF_FFFF, 200, 1, '{ST_DONE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, 0}},
      '{OP_ADD_FRONT, 32'sh8000_0000, 0, 1,
        '{ST_DONE, 32'sh8000_0000, 32'sh7FFF_FFFF, 2, 0}},
      '{OP_ADD_END, -1, 0, 1, '{ST_DONE, 32'sh8000_0000, -1, 3, 0}},
      '{OP_INSERT, 5, 3, 1, '{ST_IGNORED, 32'sh8000_0000, -1, 3, 0}},
      '{OP_INSERT, 7, 2, 0, '{default: '0}},
      '{OP_INSERT, 0, 0, 0, '{default: '0}},
      '{OP_INSERT, 32'sh1234_5678, 1, 0, '{default: '0}},
      '{OP_REM_AT, 0, 255, 0, '{default: '0}},
      '{OP_REM_AT, 0, 2, 0, '{default: '0}},
      '{OP_REM_AT, 0, 0, 0, '{default: '0}},
      '{OP_REM_AT, 0, 3, 0, '{default: '0}},
      '{OP_REM_END, 0, 0, 0, '{default: '0}},
      '{OP_BAD_LOW, 9, 0, 0, '{default: '0}},
      '{OP_BAD_HIGH, 9, 0, 0, '{default: '0}},
      '{OP_REM_FRONT, 0, 0, 0, '{default: '0}},
      '{OP_REM_END, 0, 0, 0, '{default: '0}},
      '{OP_REM_FRONT, 0, 0, 1, '{ST_IGNORED, 0, 0, 0, 1}}
   };

   initial begin
      head_q = '0;
      tail_q = '0;
      free_head_q = '0;
      list_len = 0;
      free_len = 0;
      fresh_used = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table
      foreach (stim_table[i])
         issue_word(stim_table[i].op, stim_table[i].value, stim_table[i].pos,
                    stim_table[i].typed, stim_table[i].report);

      // Fill the pool to capacity, try each add while full, then remove and refill one slot
      while (list_len < Capacity) issue_word(OP_ADD_END, pick_value(), 0);
      issue_word(OP_ADD_FRONT, 1, 0);
      issue_word(OP_ADD_END, 2, 0);
      issue_word(OP_INSERT, 3, 100);
      issue_word(OP_INSERT, 4, 255);
      issue_word(OP_REM_AT, 0, 255);
      issue_word(OP_REM_AT, 0, 128);
      issue_word(OP_INSERT, 5, 0);

      // Random phases: sender gaps 21%, then 46%, then none
      for (int ph = 0; ph < 3; ph++) begin
         sender_idle_pct = ph == 0 ? 21 : (ph == 1 ? 46 : 0);
         if (ph == 2) begin
            start = 1'b0;
            while (pending_reports.size() != 0) @(negedge clock);
         end
         for (int n = 0; n < 500; n++)
            random_word(((n / 125) % 2 == 0) ? 80 : 25);
      end
      start = 1'b0;

      while (pending_reports.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
